@@ hw/rtl/frame_time_monitor_core_assert.svh @@
// Assertion macros for the frame time monitor.
`ifndef FRAME_TIME_MONITOR_CORE_ASSERT_SVH
`define FRAME_TIME_MONITOR_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FTM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hw/rtl/ftm_pkg.sv @@
// Shared types and constants of the frame time monitor.
package ftm_pkg;
    localparam int unsigned PeriodW = 24;
    localparam int unsigned AccumW  = 48;
    localparam int unsigned CfgW    = 32;
    localparam int unsigned IdxW    = 3;
    localparam logic [IdxW-1:0] RegPause    = 3'd0;
    localparam logic [IdxW-1:0] RegScale    = 3'd1;
    localparam logic [IdxW-1:0] RegMaxDelta = 3'd2;
    localparam logic [IdxW-1:0] RegInterval = 3'd3;
    localparam logic [IdxW-1:0] RegOffset   = 3'd4;
    // Shared divider: 64-bit dividend, 64-bit divisor, restoring, one bit a cycle.
    localparam int unsigned DivW = 64;
    typedef struct packed {
        logic            start;
        logic [DivW-1:0] dividend;
        logic [DivW-1:0] divisor;
    } t_div_req;
    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quotient;
    } t_div_rsp;
endpackage

@@ hw/rtl/ftm_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module ftm_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one address each per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/ftm_div.sv @@
// Iterative restoring divider shared by all divisions of the monitor.
module ftm_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ftm_pkg::t_div_req i_req,
    output ftm_pkg::t_div_rsp o_rsp
);
    localparam int unsigned W  = ftm_pkg::DivW;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_sub;

    // Shift in one dividend bit and try the subtract
    always_comb begin
        w_trial = {r_rem, r_quo[W-1]};
        w_sub   = w_trial - {1'b0, r_dvs};
        n_quo   = {r_quo[W-2:0], ~w_sub[W]};
        n_rem   = w_sub[W] ? w_trial[W-1:0] : w_sub[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

@@ hw/rtl/frame_time_monitor_core.sv @@
// Top level of the frame time monitor: sequencer, ring walk and statistics.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  request  | i_valid/o_ready, frame_period, play  | in
//  result   | o_valid/i_ready, ten result fields   | out
//  config   | i_cfg_we, i_cfg_index, i_cfg_data    | in
//
// After a request is accepted, the walk reads n ring entries (1 to
// WINDOW_DEPTH) one at a time from the period RAM, then six divisions run
// in turn on the shared 64-step divider; the result then turns valid.
// Reset is synchronous, active low; the ring needs no clearing pass.
// The result sits in an output register; o_ready stays low while it waits.
module frame_time_monitor_core #(
    parameter int unsigned WINDOW_DEPTH   = 256,
    parameter int unsigned WINDOW_SPAN_US = 1000000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_frame_period,
    input  logic        i_play_mode,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_delta_time,
    output logic [31:0] o_frame_number,
    output logic [47:0] o_elapsed_time,
    output logic [47:0] o_game_time,
    output logic [23:0] o_min_period,
    output logic [23:0] o_max_period,
    output logic [23:0] o_avg_period,
    output logic [31:0] o_frame_rate,
    output logic [15:0] o_wall_ticks,
    output logic [15:0] o_game_ticks,
    input  logic        i_cfg_we,
    input  logic [ftm_pkg::IdxW-1:0] i_cfg_index,
    input  logic [ftm_pkg::CfgW-1:0] i_cfg_data
);
    `include "frame_time_monitor_core_assert.svh"

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SW = 40;
    localparam int unsigned DW = ftm_pkg::DivW;

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_RATE, S_AVG, S_TW0, S_TW1, S_TG0, S_TG1, S_DIVW, S_OUT
    } t_state;

    t_state r_state;
    t_state r_ret;
    // Configuration
    logic        r_pause;
    logic [15:0] r_scale;
    logic [23:0] r_max_delta;
    logic [31:0] r_interval;
    logic [31:0] r_offset;
    // Architectural state
    logic [31:0]   r_frames;
    logic [47:0]   r_wall, r_game, r_old_wall, r_old_game;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    // Walk
    logic [AW-1:0] r_ridx;
    logic [FW-1:0] r_left, r_count;
    logic          r_rd_pend;
    logic [SW-1:0] r_sum;
    logic [23:0]   r_min, r_max, r_delta;
    logic [DW-1:0] r_t0;
    // Results
    logic          r_valid;
    logic [23:0]   r_avg;
    logic [31:0]   r_rate;
    logic [15:0]   r_wt, r_gt;

    ftm_pkg::t_div_req w_req;
    ftm_pkg::t_div_rsp w_rsp;
    logic [23:0]   w_rdata;
    logic [SW-1:0] w_sum_n;
    logic [39:0]   w_prod;
    logic [31:0]   w_prod_sh;
    logic [23:0]   w_delta;
    logic [DW-1:0] w_ivl;
    logic [DW-1:0] w_td;
    logic          w_accept;

    ftm_ram #(.WIDTH(24), .DEPTH(WINDOW_DEPTH)) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_accept),
        .i_waddr(r_head),
        .i_wdata(i_frame_period),
        .i_raddr(r_ridx),
        .o_rdata(w_rdata)
    );

    ftm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign o_ready  = (r_state == S_IDLE) && !r_valid;
    assign w_accept = i_valid && o_ready;

    // Scale and clamp the game step; it is zero when paused or not in play mode
    always_comb begin
        w_prod    = i_frame_period * r_scale;
        w_prod_sh = w_prod[39:8];
        w_delta   = '0;
        if (i_play_mode && !r_pause) begin
            w_delta = (w_prod_sh > {8'd0, r_max_delta}) ? r_max_delta : w_prod_sh[23:0];
        end
    end

    assign w_sum_n = r_sum + SW'(w_rdata);
    assign w_ivl   = (r_interval == '0) ? DW'(1) : DW'(r_interval);
    assign w_td    = w_rsp.quotient - r_t0;

    // Start one division in each of the six division steps of the sequencer
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = '0;
        w_req.divisor  = w_ivl;
        case (r_state)
            S_RATE: begin
                w_req.start    = 1'b1;
                w_req.dividend = DW'(r_count) * DW'(256000000);
                w_req.divisor  = DW'(r_sum);
            end
            S_AVG: begin
                w_req.start    = 1'b1;
                w_req.dividend = DW'(r_sum);
                w_req.divisor  = DW'(r_count);
            end
            S_TW0: begin
                w_req.start    = 1'b1;
                w_req.dividend = DW'(r_old_wall) + DW'(r_offset);
            end
            S_TW1: begin
                w_req.start    = 1'b1;
                w_req.dividend = DW'(r_wall) + DW'(r_offset);
            end
            S_TG0: begin
                w_req.start    = 1'b1;
                w_req.dividend = DW'(r_old_game) + DW'(r_offset);
            end
            S_TG1: begin
                w_req.start    = 1'b1;
                w_req.dividend = DW'(r_game) + DW'(r_offset);
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    // Hold state and configuration, sequence the walk and divisions, and register results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_valid     <= 1'b0;
            r_pause     <= 1'b0;
            r_scale     <= 16'd256;
            r_max_delta <= 24'd200000;
            r_interval  <= 32'd1000000;
            r_offset    <= '0;
            r_frames    <= '0;
            r_wall      <= '0;
            r_game      <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ftm_pkg::RegPause:    r_pause     <= i_cfg_data[0];
                    ftm_pkg::RegScale:    r_scale     <= i_cfg_data[15:0];
                    ftm_pkg::RegMaxDelta: r_max_delta <= i_cfg_data[23:0];
                    ftm_pkg::RegInterval: r_interval  <= i_cfg_data;
                    ftm_pkg::RegOffset:   r_offset    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_delta    <= w_delta;
                        r_frames   <= r_frames + 1'b1;
                        r_old_wall <= r_wall;
                        r_old_game <= r_game;
                        r_wall     <= r_wall + 48'(i_frame_period);
                        r_game     <= r_game + 48'(w_delta);
                        r_head     <= (r_head == AW'(WINDOW_DEPTH - 1)) ? '0
                                      : AW'(r_head + 1'b1);
                        r_ridx     <= r_head;
                        r_left     <= (r_fill == FW'(WINDOW_DEPTH)) ? r_fill : r_fill + 1'b1;
                        r_count    <= '0;
                        r_sum      <= '0;
                        r_min      <= '1;
                        r_max      <= '0;
                        r_rd_pend  <= 1'b0;
                        r_state    <= S_WALK;
                    end
                end
                S_WALK: begin
                    // Issue a read, then fold the entry in the next cycle
                    if (!r_rd_pend) begin
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_rd_pend <= 1'b0;
                        r_sum     <= w_sum_n;
                        r_count   <= r_count + 1'b1;
                        if (w_rdata < r_min) r_min <= w_rdata;
                        if (w_rdata > r_max) r_max <= w_rdata;
                        r_ridx    <= (r_ridx == '0) ? AW'(WINDOW_DEPTH - 1)
                                     : AW'(r_ridx - 1'b1);
                        r_left    <= r_left - 1'b1;
                        if (r_left == FW'(1) || w_sum_n >= SW'(WINDOW_SPAN_US)) begin
                            r_fill  <= r_count + 1'b1;
                            r_state <= S_RATE;
                        end
                    end
                end
                S_RATE: begin
                    r_ret   <= S_AVG;
                    r_state <= S_DIVW;
                end
                S_AVG: begin
                    r_ret   <= S_TW0;
                    r_state <= S_DIVW;
                end
                S_TW0: begin
                    r_ret   <= S_TW1;
                    r_state <= S_DIVW;
                end
                S_TW1: begin
                    r_ret   <= S_TG0;
                    r_state <= S_DIVW;
                end
                S_TG0: begin
                    r_ret   <= S_TG1;
                    r_state <= S_DIVW;
                end
                S_TG1: begin
                    r_ret   <= S_OUT;
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    // Collect the quotient for the step that started it
                    if (w_rsp.done) begin
                        r_state <= r_ret;
                        case (r_ret)
                            S_AVG: begin
                                r_rate <= (r_sum == '0 || w_rsp.quotient[63:32] != '0)
                                    ? 32'hFFFF_FFFF : w_rsp.quotient[31:0];
                            end
                            S_TW0: r_avg <= w_rsp.quotient[23:0];
                            S_TW1: r_t0  <= w_rsp.quotient;
                            S_TG0: begin
                                r_wt <= (w_rsp.quotient < r_t0) ? 16'd0
                                    : (w_td[63:16] != '0) ? 16'hFFFF : w_td[15:0];
                                r_t0 <= w_rsp.quotient;
                            end
                            S_TG1: r_t0 <= w_rsp.quotient;
                            S_OUT: begin
                                r_gt <= (w_rsp.quotient < r_t0) ? 16'd0
                                    : (w_td[63:16] != '0) ? 16'hFFFF : w_td[15:0];
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_delta_time   = r_delta;
    assign o_frame_number = r_frames;
    assign o_elapsed_time = r_wall;
    assign o_game_time    = r_game;
    assign o_min_period   = r_min;
    assign o_max_period   = r_max;
    assign o_avg_period   = r_avg;
    assign o_frame_rate   = r_rate;
    assign o_wall_ticks   = r_wt;
    assign o_game_ticks   = r_gt;

    `FTM_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready, "ready while busy")
    `FTM_ASSERT_IMP(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill <= FW'(WINDOW_DEPTH), "fill overflow")
    `FTM_ASSERT_NEXT(a_out_sets_valid, i_clk, i_rst_n, r_state == S_OUT, o_valid, "result lost")
endmodule
